/* design/substring_search_with_tail_defines.svh */
// Assertion macros shared by the checker of the substring search block.
// Needs nothing else; included by the checker file.
`ifndef SUBSTRING_SEARCH_WITH_TAIL_DEFINES_SVH
`define SUBSTRING_SEARCH_WITH_TAIL_DEFINES_SVH

// same-cycle implication, clocked on clock, off during reset
`define SSWT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SSWT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/sswt_pkg.sv */
// Types and constants of the substring search block.
// No dependencies; imported by every module of the block.
package sswt_pkg;

   localparam int NEEDLE_BYTES = 16;  // storage of the needle registers
   localparam int LEN_W        = 5;   // needle_len / match_len width
   localparam int POS_W        = 16;  // match_pos width
   localparam int CSR_DATA_W   = 64;
   localparam int RSP_W        = 24;  // 1+1+16+5+1 bits

   typedef enum logic [1:0] {
      REG_NEEDLE_LOW  = 2'd0,
      REG_NEEDLE_HIGH = 2'd1,
      REG_NEEDLE_LEN  = 2'd2,
      REG_TAIL_MODE   = 2'd3
   } csr_index_type;

   typedef logic [NEEDLE_BYTES-1:0][7:0] needle_type;

   typedef struct packed {
      needle_type       needle;
      logic [LEN_W-1:0] needle_len;
      logic             tail_mode;
   } cfg_type;

   typedef struct packed {
      logic             full_ok;   // newest len bytes equal the needle
      logic             tail_hit;  // some proper prefix matches the buffer end
      logic [LEN_W-1:0] tail_len;  // longest such prefix
   } match_res_type;

endpackage

/* design/sswt_csr.sv */
// Configuration registers of the substring search block.
// Depends on sswt_pkg.
module sswt_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  sswt_pkg::csr_index_type          csr_index,
   input  logic [sswt_pkg::CSR_DATA_W-1:0]  csr_data,
   output sswt_pkg::cfg_type                cfg
);
   import sswt_pkg::*;

   logic [CSR_DATA_W-1:0] low_ff, low_in;
   logic [CSR_DATA_W-1:0] high_ff, high_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic                  tail_ff, tail_in;

   assign csr_ready = 1'b1;

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      len_in  = len_ff;
      tail_in = tail_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_NEEDLE_LOW:  low_in  = csr_data;
            REG_NEEDLE_HIGH: high_in = csr_data;
            REG_NEEDLE_LEN:  len_in  = csr_data[LEN_W-1:0];
            REG_TAIL_MODE:   tail_in = csr_data[0];
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= '0;
         high_ff <= '0;
         len_ff  <= LEN_W'(1);
         tail_ff <= 1'b0;
      end else begin
         low_ff  <= low_in;
         high_ff <= high_in;
         len_ff  <= len_in;
         tail_ff <= tail_in;
      end
   end

   assign cfg.needle     = {high_ff, low_ff};
   assign cfg.needle_len = len_ff;
   assign cfg.tail_mode  = tail_ff;

endmodule

/* design/sswt_match.sv */
// Parallel window compare: every suffix length against the needle prefix.
// Depends on sswt_pkg; used by the top level.
module sswt_match #(
   parameter int NEEDLE_MAX = 16,
   parameter int CNT_W      = 17
) (
   input  logic [NEEDLE_MAX-1:0][7:0]    seq,     // seq[0] newest byte
   input  sswt_pkg::needle_type          needle,
   input  logic [sswt_pkg::LEN_W-1:0]    len,     // already clamped to 1..NEEDLE_MAX
   input  logic [CNT_W-1:0]              n,       // bytes in buffer incl. newest
   output sswt_pkg::match_res_type       res
);
   import sswt_pkg::*;

   logic [NEEDLE_MAX-1:0][NEEDLE_MAX-1:0] eq;   // eq[d][m]: seq[d] == needle[m]
   logic [NEEDLE_MAX:1]                   hits;

   always_comb begin
      for (int d = 0; d < NEEDLE_MAX; d++) begin
         for (int m = 0; m < NEEDLE_MAX; m++) begin
            eq[d][m] = (seq[d] == needle[m]);
         end
      end
   end

   // hits[k]: the newest k bytes equal needle bytes 0..k-1
   always_comb begin
      for (int k = 1; k <= NEEDLE_MAX; k++) begin
         hits[k] = 1'b1;
         for (int m = 0; m < NEEDLE_MAX; m++) begin
            if (m < k) begin
               hits[k] = hits[k] & eq[k-1-m][m];
            end
         end
      end
   end

   always_comb begin
      res.full_ok  = 1'b0;
      res.tail_hit = 1'b0;
      res.tail_len = '0;
      for (int k = 1; k <= NEEDLE_MAX; k++) begin
         if (len == LEN_W'(k) && n >= CNT_W'(k) && hits[k]) begin
            res.full_ok = 1'b1;
         end
      end
      // ascending scan, so the longest prefix wins
      for (int k = 1; k < NEEDLE_MAX; k++) begin
         if (LEN_W'(k) < len && CNT_W'(k) <= n && hits[k]) begin
            res.tail_hit = 1'b1;
            res.tail_len = LEN_W'(k);
         end
      end
   end

endmodule

/* design/substring_search_with_tail.sv */
// Top level of the streaming substring search with tail match.
// Depends on sswt_pkg, sswt_csr and sswt_match.
//
//   channel  dir  payload                                   beat taken when
//   req_     in   tdata[7:0] data_byte, tlast last_byte     req_tvalid & req_tready
//   rsp_     out  tdata see port comment                    rsp_tvalid & rsp_tready
//   csr_     in   csr_index register, csr_data value        csr_valid & csr_ready
//
// One byte per cycle sustained while no last byte waits on a full result register.
// The window compare runs while a beat sits in the input register, and the result
// register loads as the last beat leaves it; a result passes both registers in turn.
// Reset clears the counters, flags and valid bits; registers return to defaults.
// Only a last byte waits on a full result register; other bytes keep flowing.
module substring_search_with_tail #(
   parameter int              NEEDLE_MAX = 16,
   parameter longint unsigned BUFFER_MAX = 65536
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // [7:0] data_byte
   input  logic                             req_tlast,   // last_byte
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] found, [1] partial, [17:2] match_pos, [22:18] match_len, [23] overflow
   output logic [sswt_pkg::RSP_W-1:0]       rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  sswt_pkg::csr_index_type          csr_index,
   input  logic [sswt_pkg::CSR_DATA_W-1:0]  csr_data
);
   import sswt_pkg::*;

   localparam int CNT_W = $clog2(BUFFER_MAX + 1);
   localparam int WIN_D = NEEDLE_MAX - 1;

   cfg_type       cfg;
   match_res_type mres;

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;

   // stream state
   logic [7:0]       win_ff [WIN_D];
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             hit_ff, hit_in;
   logic [POS_W-1:0] hit_pos_ff, hit_pos_in;
   logic             ovf_ff, ovf_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic                       out_free, s1_go;
   logic                       cnt_full, ovf_new, new_hit, hit_new;
   logic [CNT_W-1:0]           n, full_diff, tail_diff;
   logic [POS_W-1:0]           pos_new;
   logic [LEN_W-1:0]           len_eff;
   logic [NEEDLE_MAX-1:0][7:0] seq;
   logic                       r_found, r_partial;
   logic [POS_W-1:0]           r_pos;
   logic [LEN_W-1:0]           r_len;

   sswt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_go      = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_tready = !s1_valid_ff || s1_go;

   always_comb begin
      if (cfg.needle_len == '0) begin
         len_eff = LEN_W'(1);
      end else if (cfg.needle_len > LEN_W'(NEEDLE_MAX)) begin
         len_eff = LEN_W'(NEEDLE_MAX);
      end else begin
         len_eff = cfg.needle_len;
      end
   end

   always_comb begin
      seq[0] = s1_byte_ff;
      for (int d = 1; d < NEEDLE_MAX; d++) begin
         seq[d] = win_ff[d-1];
      end
   end

   // count saturates at BUFFER_MAX; n = 0 once saturated blocks any match
   assign cnt_full = (cnt_ff == CNT_W'(BUFFER_MAX));
   assign ovf_new  = ovf_ff || cnt_full;
   assign n        = cnt_full ? '0 : cnt_ff + CNT_W'(1);

   sswt_match #(
      .NEEDLE_MAX (NEEDLE_MAX),
      .CNT_W      (CNT_W)
   ) u_match (
      .seq    (seq),
      .needle (cfg.needle),
      .len    (len_eff),
      .n      (n),
      .res    (mres)
   );

   assign full_diff = n - CNT_W'(len_eff);
   assign tail_diff = n - CNT_W'(mres.tail_len);
   assign new_hit   = !ovf_new && !hit_ff && mres.full_ok;
   assign hit_new   = hit_ff || new_hit;
   assign pos_new   = new_hit ? POS_W'(full_diff) : hit_pos_ff;

   always_comb begin
      r_found   = 1'b0;
      r_partial = 1'b0;
      r_pos     = '0;
      r_len     = '0;
      if (hit_new) begin
         r_found = 1'b1;
         r_pos   = pos_new;
         r_len   = len_eff;
      end else if (cfg.tail_mode && !ovf_new && mres.tail_hit) begin
         r_found   = 1'b1;
         r_partial = 1'b1;
         r_pos     = POS_W'(tail_diff);
         r_len     = mres.tail_len;
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      cnt_in       = cnt_ff;
      hit_in       = hit_ff;
      hit_pos_in   = hit_pos_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_go) begin
         s1_valid_in = 1'b0;
         if (s1_last_ff) begin
            cnt_in       = '0;
            hit_in       = 1'b0;
            hit_pos_in   = '0;
            ovf_in       = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_data_in  = {ovf_new, r_len, r_pos, r_partial, r_found};
         end else begin
            cnt_in     = cnt_full ? cnt_ff : n;
            hit_in     = hit_new;
            hit_pos_in = pos_new;
            ovf_in     = ovf_new;
         end
      end
      if (req_tvalid && req_tready) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         cnt_ff       <= '0;
         hit_ff       <= 1'b0;
         hit_pos_ff   <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         cnt_ff       <= cnt_in;
         hit_ff       <= hit_in;
         hit_pos_ff   <= hit_pos_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset; stale window bytes are masked by the byte count
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_byte_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
      if (s1_go) begin
         win_ff[0] <= s1_byte_ff;
         for (int d = 1; d < WIN_D; d++) begin
            win_ff[d] <= win_ff[d-1];
         end
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* design/sswt_checker.sv */
// Port-level checks of the substring search block, bound to the top level.
// Depends on sswt_pkg and substring_search_with_tail_defines.svh.
`include "substring_search_with_tail_defines.svh"

module sswt_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [sswt_pkg::RSP_W-1:0] rsp_tdata,
   input logic                       csr_ready
);
   import sswt_pkg::*;

   logic             found, partial, ovf;
   logic [LEN_W-1:0] mlen;

   assign found   = rsp_tdata[0];
   assign partial = rsp_tdata[1];
   assign mlen    = rsp_tdata[22:18];
   assign ovf     = rsp_tdata[23];

   // a stalled result beat keeps its payload
   `SSWT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp beat changed while stalled")

   // no match means position, length and partial are all zero
   `SSWT_ASSERT_NOW(a_miss_zero, clock, reset, rsp_tvalid && !found, rsp_tdata[22:1] == '0, "miss with nonzero fields")

   // a match always carries a length
   `SSWT_ASSERT_NOW(a_hit_len, clock, reset, rsp_tvalid && found, mlen != '0, "match with zero length")

   // a prefix match is never reported for an overflowed buffer
   `SSWT_ASSERT_NOW(a_ovf_tail, clock, reset, rsp_tvalid && ovf, !partial, "tail match after overflow")

   `SSWT_ASSERT_NOW(a_csr_ready, clock, reset, 1'b1, csr_ready, "config port not ready")

endmodule

bind substring_search_with_tail sswt_checker u_sswt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_ready  (csr_ready)
);
